@@ rtl/core/nrgms_pkg.sv @@
// ----------------------------------------------------------------------------
// nrgms_pkg
// Shared constants, command codes and controller/datapath handshake types
// for the worker-slot registry with greedy memory selection.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package nrgms_pkg;

    localparam int CMD_W   = 2;
    localparam int SLOT_W  = 4;
    localparam int MEM_W   = 16;
    localparam int TOTAL_W = 20;
    localparam int AGE_W   = 5;

    localparam int MAX_RESULTS = 16;
    localparam int BUF_AW      = $clog2(MAX_RESULTS);
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    localparam logic [AGE_W-1:0]   AGE_MAX       = 5'd31;
    localparam logic [AGE_W-1:0]   TIMEOUT_RESET = 5'd15;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX     = 20'hFFFFF;

    localparam logic [CMD_W-1:0] CMD_HEARTBEAT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TICK      = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SELECT    = 2'd2;

    // Controller to datapath
    typedef struct packed {
        logic hb_write;
        logic tick;
        logic sel_start;
        logic scan_step;
        logic pick;
        logic emit_load;
        logic fail_load;
    } nrgms_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic scan_done;
        logic best_found;
        logic covered;
        logic picks_full;
        logic emit_last;
        logic out_free;
    } nrgms_stat_t;

endpackage

@@ rtl/core/nrgms_if.sv @@
// ----------------------------------------------------------------------------
// nrgms interfaces
// Valid/ready channels for command items, result items and the timeout
// register write port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface nrgms_in_if;
    import nrgms_pkg::*;
    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   cmd;
    logic [SLOT_W-1:0]  slot_index;
    logic [MEM_W-1:0]   avail_mem;
    logic [MEM_W-1:0]   request_size;

    modport source (output valid, cmd, slot_index, avail_mem, request_size,
                    input ready);
    modport sink   (input valid, cmd, slot_index, avail_mem, request_size,
                    output ready);
endinterface

interface nrgms_out_if;
    import nrgms_pkg::*;
    logic               valid;
    logic               ready;
    logic [SLOT_W-1:0]  chosen_slot;
    logic [TOTAL_W-1:0] running_total;
    logic               failed;
    logic               last;

    modport source (output valid, chosen_slot, running_total, failed, last,
                    input ready);
    modport sink   (input valid, chosen_slot, running_total, failed, last,
                    output ready);
endinterface

interface nrgms_cfg_if;
    import nrgms_pkg::*;
    logic               valid;
    logic               ready;
    logic [AGE_W-1:0]   timeout_seconds;

    modport source (output valid, timeout_seconds, input ready);
    modport sink   (input valid, timeout_seconds, output ready);
endinterface

@@ rtl/core/nrgms_datapath.sv @@
// ----------------------------------------------------------------------------
// nrgms_datapath
// Slot table, aging, max-memory scan unit, pick buffer and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nrgms_datapath
    import nrgms_pkg::*;
#(
    parameter int SLOTS = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  nrgms_cmd_t          ctl,
    output nrgms_stat_t         stat,
    input  logic [SLOT_W-1:0]   slot_index,
    input  logic [MEM_W-1:0]    avail_mem,
    input  logic [MEM_W-1:0]    request_size,
    input  logic                cfg_we,
    input  logic [AGE_W-1:0]    cfg_timeout,
    output logic                res_valid,
    input  logic                res_ready,
    output logic [SLOT_W-1:0]   chosen_slot,
    output logic [TOTAL_W-1:0]  running_total,
    output logic                failed,
    output logic                last
);

    localparam int AW    = $clog2(SLOTS);
    localparam int CW    = $clog2(SLOTS + 1);
    localparam int SUM_W = (MEM_W + AW > TOTAL_W) ? (MEM_W + AW) : TOTAL_W;

    // Slot table
    logic [MEM_W-1:0]  slot_mem [SLOTS];
    logic [SLOTS-1:0]  valid_reg, valid_next;
    logic [AGE_W-1:0]  age_reg  [SLOTS];
    logic [AGE_W-1:0]  age_next [SLOTS];
    logic [AGE_W-1:0]  age_sat  [SLOTS];
    logic [AGE_W-1:0]  timeout_reg;

    // Scan unit
    logic [CW-1:0]     scan_reg;
    logic              pipe_vld_reg;
    logic              pipe_live_reg;
    logic [AW-1:0]     pipe_idx_reg;
    logic [MEM_W-1:0]  pipe_mem_reg;
    logic              best_found_reg;
    logic [AW-1:0]     best_idx_reg;
    logic [MEM_W-1:0]  best_mem_reg;
    logic              first_pass_reg;
    logic [SLOTS-1:0]  taken_reg;

    // Selection state
    logic [MEM_W-1:0]  request_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [SUM_W-1:0]  sum_next;
    logic [SUM_W-1:0]  all_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [BUF_AW-1:0] emit_idx_reg;
    logic [SLOT_W-1:0] buf_slot [MAX_RESULTS];
    logic [TOTAL_W-1:0] buf_sum [MAX_RESULTS];

    // Result register
    logic               res_valid_reg;
    logic [SLOT_W-1:0]  res_slot_reg;
    logic [TOTAL_W-1:0] res_total_reg;
    logic               res_failed_reg;
    logic               res_last_reg;

    logic              hb_in_range;
    logic [AW-1:0]     hb_addr;
    logic              issue;
    logic              take_pipe;
    logic              pick_hit;
    logic [TOTAL_W-1:0] all_sat;

    assign hb_in_range = 32'(slot_index) < 32'(SLOTS);
    assign hb_addr     = AW'(slot_index);
    assign issue       = ctl.scan_step && (scan_reg != CW'(SLOTS));
    assign take_pipe   = pipe_vld_reg && pipe_live_reg &&
                         (!best_found_reg || (pipe_mem_reg > best_mem_reg));
    assign pick_hit    = ctl.pick && best_found_reg;
    assign sum_next    = sum_reg + SUM_W'(best_mem_reg);
    assign all_sat     = (all_reg > SUM_W'(TOTAL_MAX)) ? TOTAL_MAX : TOTAL_W'(all_reg);

    assign stat.scan_done  = (scan_reg == CW'(SLOTS));
    assign stat.best_found = best_found_reg;
    assign stat.covered    = sum_next >= SUM_W'(request_reg);
    assign stat.picks_full = (count_reg == CNT_W'(MAX_RESULTS - 1));
    assign stat.emit_last  = (CNT_W'(emit_idx_reg) == (count_reg - CNT_W'(1)));
    assign stat.out_free   = !res_valid_reg || res_ready;

    // On a tick, age every valid slot, saturating; drop on timeout; heartbeat revives
    always_comb
    begin
        valid_next = valid_reg;
        for (int i = 0; i < SLOTS; i++)
        begin
            age_next[i] = age_reg[i];
            age_sat[i]  = (age_reg[i] == AGE_MAX) ? AGE_MAX : AGE_W'(age_reg[i] + 1'b1);
            if (ctl.tick && valid_reg[i])
            begin
                age_next[i] = age_sat[i];
                if (age_sat[i] > timeout_reg)
                begin
                    valid_next[i] = 1'b0;
                end
            end
        end
        if (ctl.hb_write && hb_in_range)
        begin
            valid_next[hb_addr] = 1'b1;
            age_next[hb_addr]   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            timeout_reg <= TIMEOUT_RESET;
            for (int i = 0; i < SLOTS; i++)
            begin
                age_reg[i] <= '0;
            end
        end
        else
        begin
            valid_reg <= valid_next;
            for (int i = 0; i < SLOTS; i++)
            begin
                age_reg[i] <= age_next[i];
            end
            if (cfg_we)
            begin
                timeout_reg <= cfg_timeout;
            end
        end
    end

    // Memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (ctl.hb_write && hb_in_range)
        begin
            slot_mem[hb_addr] <= avail_mem;
        end
        if (issue)
        begin
            pipe_mem_reg <= slot_mem[scan_reg[AW-1:0]];
        end
    end

    // Scan control and selection bookkeeping
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_reg       <= '0;
            pipe_vld_reg   <= 1'b0;
            best_found_reg <= 1'b0;
            first_pass_reg <= 1'b0;
            taken_reg      <= '0;
            count_reg      <= '0;
            emit_idx_reg   <= '0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            if (ctl.sel_start || ctl.pick)
            begin
                scan_reg       <= '0;
                pipe_vld_reg   <= 1'b0;
                best_found_reg <= 1'b0;
            end
            else if (ctl.scan_step)
            begin
                pipe_vld_reg <= issue;
                if (issue)
                begin
                    scan_reg <= scan_reg + CW'(1);
                end
                if (take_pipe)
                begin
                    best_found_reg <= 1'b1;
                end
            end

            if (ctl.sel_start)
            begin
                first_pass_reg <= 1'b1;
                taken_reg      <= '0;
                count_reg      <= '0;
                emit_idx_reg   <= '0;
            end
            else if (ctl.pick)
            begin
                first_pass_reg <= 1'b0;
                if (best_found_reg)
                begin
                    taken_reg[best_idx_reg] <= 1'b1;
                    count_reg               <= count_reg + CNT_W'(1);
                end
            end

            if (ctl.emit_load)
            begin
                emit_idx_reg <= emit_idx_reg + BUF_AW'(1);
            end

            if (ctl.emit_load || ctl.fail_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            pipe_live_reg <= valid_reg[scan_reg[AW-1:0]] && !taken_reg[scan_reg[AW-1:0]];
            pipe_idx_reg  <= scan_reg[AW-1:0];
        end
        if (ctl.scan_step && take_pipe)
        begin
            best_idx_reg <= pipe_idx_reg;
            best_mem_reg <= pipe_mem_reg;
        end
        if (ctl.sel_start)
        begin
            request_reg <= request_size;
            sum_reg     <= '0;
            all_reg     <= '0;
        end
        else
        begin
            if (ctl.scan_step && pipe_vld_reg && pipe_live_reg && first_pass_reg)
            begin
                all_reg <= all_reg + SUM_W'(pipe_mem_reg);
            end
            if (pick_hit)
            begin
                sum_reg <= sum_next;
            end
        end
        if (pick_hit)
        begin
            buf_slot[count_reg[BUF_AW-1:0]] <= SLOT_W'(best_idx_reg);
            buf_sum[count_reg[BUF_AW-1:0]]  <= TOTAL_W'(sum_next);
        end
        if (ctl.emit_load)
        begin
            res_slot_reg   <= buf_slot[emit_idx_reg];
            res_total_reg  <= buf_sum[emit_idx_reg];
            res_failed_reg <= 1'b0;
            res_last_reg   <= stat.emit_last;
        end
        else if (ctl.fail_load)
        begin
            res_slot_reg   <= '0;
            res_total_reg  <= all_sat;
            res_failed_reg <= 1'b1;
            res_last_reg   <= 1'b1;
        end
    end

    assign res_valid     = res_valid_reg;
    assign chosen_slot   = res_slot_reg;
    assign running_total = res_total_reg;
    assign failed        = res_failed_reg;
    assign last          = res_last_reg;

endmodule

@@ rtl/core/nrgms_ctrl.sv @@
// ----------------------------------------------------------------------------
// nrgms_ctrl
// Sequencer: accepts command beats, runs the scan/pick loop of a select and
// hands results to the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nrgms_ctrl
    import nrgms_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [CMD_W-1:0]  cmd,
    input  nrgms_stat_t       stat,
    output nrgms_cmd_t        ctl
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PICK,
        ST_EMIT,
        ST_FAIL
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    case (cmd)
                        CMD_HEARTBEAT: ctl.hb_write = 1'b1;
                        CMD_TICK:      ctl.tick     = 1'b1;
                        CMD_SELECT:
                        begin
                            ctl.sel_start = 1'b1;
                            state_next    = ST_SCAN;
                        end
                        default: ;
                    endcase
                end
            end
            ST_SCAN:
            begin
                ctl.scan_step = 1'b1;
                if (stat.scan_done)
                begin
                    state_next = ST_PICK;
                end
            end
            ST_PICK:
            begin
                ctl.pick = 1'b1;
                if (!stat.best_found)
                begin
                    state_next = ST_FAIL;
                end
                else if (stat.covered)
                begin
                    state_next = ST_EMIT;
                end
                else if (stat.picks_full)
                begin
                    state_next = ST_FAIL;
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    ctl.emit_load = 1'b1;
                    if (stat.emit_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_FAIL:
            begin
                if (stat.out_free)
                begin
                    ctl.fail_load = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ rtl/core/node_registry_greedy_memory_select.sv @@
// ----------------------------------------------------------------------------
// node_registry_greedy_memory_select
// Worker-slot registry with largest-first memory selection.
// Heartbeat and tick: applied while idle, next beat taken the cycle after.
// Select: each pick scans every slot through the single memory read port;
//   after k picks, the k result beats are sent from the pick buffer as the
//   output register frees; a failed select sends one failed beat.
// Reset: all slots invalid, ages zero, timeout 15; no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module node_registry_greedy_memory_select
    import nrgms_pkg::*;
#(
    parameter int SLOTS = 16
)
(
    input  logic     clk,
    input  logic     rst_n,
    nrgms_in_if.sink   item,
    nrgms_out_if.source result,
    nrgms_cfg_if.sink  cfg
);

    nrgms_cmd_t  ctl;
    nrgms_stat_t stat;

    assign cfg.ready = 1'b1;

    nrgms_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (item.valid),
        .in_ready (item.ready),
        .cmd      (item.cmd),
        .stat     (stat),
        .ctl      (ctl)
    );

    nrgms_datapath #(
        .SLOTS (SLOTS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .stat          (stat),
        .slot_index    (item.slot_index),
        .avail_mem     (item.avail_mem),
        .request_size  (item.request_size),
        .cfg_we        (cfg.valid),
        .cfg_timeout   (cfg.timeout_seconds),
        .res_valid     (result.valid),
        .res_ready     (result.ready),
        .chosen_slot   (result.chosen_slot),
        .running_total (result.running_total),
        .failed        (result.failed),
        .last          (result.last)
    );

endmodule
